// File: hw/rtl/mh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mh_pkg
// Shared types and constants for the magnetometer heading pipeline.
// ----------------------------------------------------------------------------
package mh_pkg;

	// datapath widths
	localparam int CW = 33;	// CORDIC x/y, calibrated axis times 256 plus gain
	localparam int ZW = 34;	// angle, 1/65536 centidegree
	localparam int ATAN_ENTRIES = 24;

	// register index within the APB map (paddr[4:2])
	localparam logic [2:0] REG_X_SCALE  = 3'd0;
	localparam logic [2:0] REG_Y_SCALE  = 3'd1;
	localparam logic [2:0] REG_X_OFFSET = 3'd2;
	localparam logic [2:0] REG_Y_OFFSET = 3'd3;
	localparam logic [2:0] REG_DECL     = 3'd4;

	localparam logic signed [15:0] X_SCALE_RST  = 16'sd4096;
	localparam logic signed [15:0] Y_SCALE_RST  = 16'sd4096;
	localparam logic signed [20:0] X_OFFSET_RST = 21'sd0;
	localparam logic signed [20:0] Y_OFFSET_RST = 21'sd0;
	localparam logic signed [15:0] DECL_RST     = 16'sd475;

	localparam logic signed [15:0] DECL_MAX = 16'sd18000;
	localparam logic signed [15:0] DECL_MIN = -16'sd18000;

	// 180 and 360 degrees in angle units
	localparam logic signed [ZW-1:0] ANG_HALF = ZW'(64'sd1179648000);
	localparam logic signed [ZW-1:0] ANG_FULL = ZW'(64'sd2359296000);

	// floor(c / 100) = (c * RECIP_100) >> RECIP_SHIFT for c <= 36000
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// atan(2^-i), 1/65536 centidegree
	localparam logic [28:0] ATAN_TAB [ATAN_ENTRIES] = '{
		29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507,
		29'd23437865,  29'd11730478,  29'd5866610,  29'd2933484,
		29'd1466765,   29'd733385,    29'd366693,   29'd183346,
		29'd91673,     29'd45837,     29'd22918,    29'd11459,
		29'd5730,      29'd2865,      29'd1432,     29'd716,
		29'd358,       29'd179,       29'd90,       29'd45
	};

	typedef struct packed {
		logic                 zero;	// calibrated vector was 0,0
		logic signed [CW-1:0] u;
		logic signed [CW-1:0] v;
		logic signed [ZW-1:0] z;
	} mh_cord_t;

endpackage
`default_nettype wire

// File: hw/rtl/mh_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mh_cordic_stage
// One vectoring-mode CORDIC iteration with its pipeline register.
// ----------------------------------------------------------------------------
module mh_cordic_stage
	import mh_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  wire mh_cord_t in_data,
	output logic          out_valid,
	output mh_cord_t      out_data
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[SHIFT]);

	logic signed [CW-1:0] u_in;
	logic signed [CW-1:0] v_in;
	logic signed [ZW-1:0] z_in;
	logic signed [CW-1:0] du;
	logic signed [CW-1:0] dv;
	mh_cord_t             nxt;
	logic                 vld_s1;
	mh_cord_t             data_s1;

	assign u_in = in_data.u;
	assign v_in = in_data.v;
	assign z_in = in_data.z;
	assign du   = v_in >>> SHIFT;
	assign dv   = u_in >>> SHIFT;

	always_comb begin
		nxt.zero = in_data.zero;
		if (!v_in[CW-1]) begin
			nxt.u = u_in + du;
			nxt.v = v_in - dv;
			nxt.z = z_in + ATAN;
		end else begin
			nxt.u = u_in - du;
			nxt.v = v_in + dv;
			nxt.z = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// File: hw/rtl/magnetometer_heading.sv
`default_nettype none
// A request passes through registers s1, s2, s3, the CORDIC stages, s5, s6 and s7 to the heading.
// Throughput: one request per cycle unless out_ready stalls it; every stage has its
// own valid bit and a stage loads whenever it is empty or the stage after it moves.
// Reset (arst_n low) empties the pipeline and loads the calibration registers
// with their defaults (unity scale, zero offsets, 4.75 deg declination).
// ----------------------------------------------------------------------------
// magnetometer_heading
// Compass heading from raw X/Y magnetometer samples: per-axis calibration,
// pipelined CORDIC atan2, declination add and wrap to whole degrees 0..360.
// ----------------------------------------------------------------------------
module magnetometer_heading
	import mh_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_WIDTH  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// sample channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] mag_x,
	input  wire logic signed [15:0] mag_y,
	// heading channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [8:0]  heading_degrees,
	// APB configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [4:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready
);

	localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int SEXT = 16 - SAMPLE_WIDTH;

	// ---------------- configuration registers ----------------
	logic signed [15:0] x_scale_q;
	logic signed [15:0] y_scale_q;
	logic signed [20:0] x_offset_q;
	logic signed [20:0] y_offset_q;
	logic signed [15:0] decl_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q  <= X_SCALE_RST;
			y_scale_q  <= Y_SCALE_RST;
			x_offset_q <= X_OFFSET_RST;
			y_offset_q <= Y_OFFSET_RST;
			decl_q     <= DECL_RST;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_X_SCALE:  x_scale_q  <= pwdata[15:0];
				REG_Y_SCALE:  y_scale_q  <= pwdata[15:0];
				REG_X_OFFSET: x_offset_q <= pwdata[20:0];
				REG_Y_OFFSET: y_offset_q <= pwdata[20:0];
				REG_DECL:     decl_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_X_SCALE:  prdata = 32'(x_scale_q);
			REG_Y_SCALE:  prdata = 32'(y_scale_q);
			REG_X_OFFSET: prdata = 32'(x_offset_q);
			REG_Y_OFFSET: prdata = 32'(y_offset_q);
			REG_DECL:     prdata = 32'(decl_q);
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline flow control ----------------
	logic            en_s1, en_s2, en_s3, en_s5, en_s6, en_s7;
	logic            vld_s1, vld_s2, vld_s3, vld_s5, vld_s6, vld_s7;
	logic [NSTG:0]   cvld;
	logic [NSTG:0]   cen;

	assign en_s7    = ~vld_s7 | out_ready;
	assign en_s6    = ~vld_s6 | en_s7;
	assign en_s5    = ~vld_s5 | en_s6;
	assign cen[NSTG] = en_s5;
	assign en_s3    = ~vld_s3 | cen[0];
	assign en_s2    = ~vld_s2 | en_s3;
	assign en_s1    = ~vld_s1 | en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s5) vld_s5 <= cvld[NSTG];
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// ---------------- s1: raw * scale ----------------
	logic signed [15:0] rx_sh, ry_sh, rx, ry;
	logic signed [31:0] xp_s1, yp_s1;

	// keep only the low SAMPLE_WIDTH bits, sign-extended
	assign rx_sh = mag_x <<< SEXT;
	assign ry_sh = mag_y <<< SEXT;
	assign rx    = rx_sh >>> SEXT;
	assign ry    = ry_sh >>> SEXT;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			xp_s1 <= 32'(rx) * 32'(x_scale_q);
			yp_s1 <= 32'(ry) * 32'(y_scale_q);
		end
	end

	// ---------------- s2: >>12 + offset ----------------
	logic signed [21:0] xc_s2, yc_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			xc_s2 <= 22'(xp_s1 >>> 12) + 22'(x_offset_q);
			yc_s2 <= 22'(yp_s1 >>> 12) + 22'(y_offset_q);
		end
	end

	// ---------------- s3: zero check and left half-plane turn ----------------
	logic signed [CW-1:0] v0, u0;
	mh_cord_t             pre;
	mh_cord_t             cd_s3;

	assign v0 = CW'(xc_s2) <<< 8;
	assign u0 = CW'(yc_s2) <<< 8;

	always_comb begin
		pre.zero = (xc_s2 == '0) && (yc_s2 == '0);
		if (u0[CW-1]) begin
			pre.u = -u0;
			pre.v = -v0;
			pre.z = v0[CW-1] ? -ANG_HALF : ANG_HALF;
		end else begin
			pre.u = u0;
			pre.v = v0;
			pre.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cd_s3 <= pre;
		end
	end

	// ---------------- s4: CORDIC iterations ----------------
	mh_cord_t cd [NSTG+1];

	assign cd[0]   = cd_s3;
	assign cvld[0] = vld_s3;

	for (genvar j = 0; j < NSTG; j++) begin : g_cordic
		assign cen[j] = ~cvld[j+1] | cen[j+1];

		mh_cordic_stage #(
			.SHIFT (j)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (cen[j]),
			.in_valid  (cvld[j]),
			.in_data   (cd[j]),
			.out_valid (cvld[j+1]),
			.out_data  (cd[j+1])
		);
	end

	// ---------------- s5: declination add and wrap ----------------
	logic signed [15:0]   decl_sat;
	logic signed [ZW-1:0] ang, hsum, hwrap;
	logic        [15:0]   ang_s5;

	always_comb begin
		if (decl_q > DECL_MAX) begin
			decl_sat = DECL_MAX;
		end else if (decl_q < DECL_MIN) begin
			decl_sat = DECL_MIN;
		end else begin
			decl_sat = decl_q;
		end
		ang  = cd[NSTG].zero ? '0 : cd[NSTG].z;
		hsum = ang + (ZW'(decl_sat) <<< 16);
		if (hsum[ZW-1]) begin
			hwrap = hsum + ANG_FULL;
		end else if (hsum > ANG_FULL) begin
			hwrap = hsum - ANG_FULL;
		end else begin
			hwrap = hsum;
		end
		if (hwrap[ZW-1]) begin
			hwrap = '0;
		end
	end

	// whole centidegrees, 0..36000
	always_ff @(posedge clk) begin
		if (en_s5) begin
			ang_s5 <= hwrap[31:16];
		end
	end

	// ---------------- s6/s7: divide by 100 ----------------
	logic [28:0] prod_s6;
	logic [8:0]  hdg_s7;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			prod_s6 <= 29'(ang_s5) * 29'(RECIP_100);
		end
		if (en_s7) begin
			hdg_s7 <= prod_s6[RECIP_SHIFT+8:RECIP_SHIFT];
		end
	end

	assign out_valid       = vld_s7;
	assign heading_degrees = hdg_s7;

endmodule
`default_nettype wire
